// ===== rtl/echo_paced_line_uploader_assert.svh =====
// Assertion macros for the echo paced line uploader checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ECHO_PACED_LINE_UPLOADER_ASSERT_SVH
`define ECHO_PACED_LINE_UPLOADER_ASSERT_SVH

// same-cycle implication
`define EPLU_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define EPLU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/eplu_pkg.sv =====
// Shared types and constants for the echo paced line uploader.
// No dependencies.
`default_nettype none

package eplu_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DELAY_W    = 20;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned FAULT_W    = 2;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

  localparam logic [BYTE_W-1:0]  PROMPT_RST = 8'h3E;
  localparam logic [BYTE_W-1:0]  ERROR_RST  = 8'h3F;
  localparam logic [BYTE_W-1:0]  EXTRA_RST  = 8'd2;
  localparam logic [DELAY_W-1:0] DELAY_RST  = 20'd10000;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RX    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd3;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_ECHO  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_ERROR = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_READY   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ECHO    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PROMPT  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SWALLOW = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DELAY   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_FAULTED = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_PROMPT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]  prompt_char;
    logic [BYTE_W-1:0]  error_char;
    logic [BYTE_W-1:0]  extra_prompt_count;
    logic [DELAY_W-1:0] line_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               ready_res;
    logic               refused;
    logic [FAULT_W-1:0] fault;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/eplu_core.sv =====
// Upload sequencer: phase register, echo/prompt checks, swallow and delay counters.
// Depends on eplu_pkg.
`default_nettype none

module eplu_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [eplu_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [eplu_pkg::BYTE_W-1:0]  data_i,
  input  wire eplu_pkg::cfg_t               cfg_i,
  output eplu_pkg::res_t                    res_o
);
  import eplu_pkg::*;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [BYTE_W-1:0]  sent_q, sent_d;
  logic               armed_q, armed_d;
  logic [BYTE_W-1:0]  swallow_q, swallow_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [FAULT_W-1:0] fault_q, fault_d;

  logic [BYTE_W-1:0]  swallow_dec;
  logic [DELAY_W-1:0] delay_dec;
  logic               echo_skip;
  logic               tx_valid;
  logic [BYTE_W-1:0]  tx_byte;
  logic               refused;

  assign swallow_dec = swallow_q - BYTE_W'(1);
  assign delay_dec   = delay_q - DELAY_W'(1);
  assign echo_skip   = ((data_i == CH_CR) && (sent_q != CH_CR)) ||
                       ((data_i == CH_LF) && (sent_q != CH_LF));

  always_comb begin
    phase_d   = phase_q;
    sent_d    = sent_q;
    armed_d   = armed_q;
    swallow_d = swallow_q;
    delay_d   = delay_q;
    fault_d   = fault_q;
    tx_valid  = 1'b0;
    tx_byte   = CH_NUL;
    refused   = 1'b0;
    unique case (mode_i)
      MODE_START: begin
        fault_d   = FAULT_NONE;
        armed_d   = 1'b0;
        swallow_d = '0;
        delay_d   = '0;
        sent_d    = CH_CR;
        tx_valid  = 1'b1;
        tx_byte   = CH_CR;
        phase_d   = PH_PROMPT;
      end
      MODE_FILE: begin
        if (phase_q == PH_READY) begin
          sent_d   = (data_i == CH_LF) ? CH_CR : data_i;
          tx_valid = 1'b1;
          tx_byte  = sent_d;
          phase_d  = PH_ECHO;
        end else begin
          refused = 1'b1;
        end
      end
      MODE_RX: begin
        if (data_i != CH_NUL) begin
          case (phase_q)
            PH_ECHO: begin
              if (!echo_skip) begin
                if (data_i != sent_q) begin
                  fault_d = FAULT_ECHO;
                  phase_d = PH_FAULTED;
                end else if (sent_q == CH_CR) begin
                  armed_d = 1'b1;
                  phase_d = PH_PROMPT;
                end else begin
                  phase_d = PH_READY;
                end
              end
            end
            PH_PROMPT: begin
              if (data_i == cfg_i.prompt_char) begin
                swallow_d = cfg_i.extra_prompt_count;
                if (cfg_i.extra_prompt_count == '0) begin
                  delay_d = cfg_i.line_delay_ticks;
                  phase_d = (cfg_i.line_delay_ticks == '0) ? PH_READY : PH_DELAY;
                end else begin
                  phase_d = PH_SWALLOW;
                end
              end else if (armed_q && (data_i == cfg_i.error_char)) begin
                fault_d = FAULT_ERROR;
                phase_d = PH_FAULTED;
              end
            end
            PH_SWALLOW: begin
              swallow_d = swallow_dec;
              if (swallow_dec == '0) begin
                delay_d = cfg_i.line_delay_ticks;
                phase_d = (cfg_i.line_delay_ticks == '0) ? PH_READY : PH_DELAY;
              end
            end
            default: ;
          endcase
        end
      end
      MODE_TICK: begin
        if (phase_q == PH_DELAY) begin
          delay_d = delay_dec;
          if (delay_dec == '0) phase_d = PH_READY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      sent_q    <= '0;
      armed_q   <= 1'b0;
      swallow_q <= '0;
      delay_q   <= '0;
      fault_q   <= FAULT_NONE;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      sent_q    <= sent_d;
      armed_q   <= armed_d;
      swallow_q <= swallow_d;
      delay_q   <= delay_d;
      fault_q   <= fault_d;
    end
  end

  assign res_o.tx_valid  = tx_valid;
  assign res_o.tx_byte   = tx_byte;
  assign res_o.ready_res = (phase_d == PH_READY);
  assign res_o.refused   = refused;
  assign res_o.fault     = fault_d;

endmodule

`default_nettype wire

// ===== rtl/echo_paced_line_uploader.sv =====
// Echo paced line uploader: one input word in, one result word out, every cycle
// unless the output stalls. The sequencer updates its state in the cycle a word
// is accepted and the result lands in an output register; a new word is taken
// whenever that register is empty or being drained, so the block sustains one
// word per clock while the output is not stalled. Depends on eplu_pkg, eplu_core.
`default_nettype none

module echo_paced_line_uploader (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [eplu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [eplu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  input  wire logic [eplu_pkg::BYTE_W-1:0]       s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic [eplu_pkg::MODE_W-1:0]       s_axis_tuser_i,  // [1:0] mode
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [7:0] tx_byte, [8] ready_res, [9] refused, [11:10] fault, [15:12] zero
  output      logic [eplu_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output      logic                              m_axis_tuser_o   // [0] tx_valid
);
  import eplu_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t res_q;
  logic out_valid_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prompt_char        <= PROMPT_RST;
      cfg_q.error_char         <= ERROR_RST;
      cfg_q.extra_prompt_count <= EXTRA_RST;
      cfg_q.line_delay_ticks   <= DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROMPT: cfg_q.prompt_char        <= cfg_data_i[BYTE_W-1:0];
        CFG_ERROR:  cfg_q.error_char         <= cfg_data_i[BYTE_W-1:0];
        CFG_EXTRA:  cfg_q.extra_prompt_count <= cfg_data_i[BYTE_W-1:0];
        CFG_DELAY:  cfg_q.line_delay_ticks   <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  eplu_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (s_axis_tuser_i),
    .data_i   (s_axis_tdata_i),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.tx_valid;
  assign m_axis_tdata_o  = {4'b0000, res_q.fault, res_q.refused, res_q.ready_res,
                            res_q.tx_byte};

endmodule

`default_nettype wire

// ===== rtl/eplu_checker.sv =====
// Port-level checks for echo_paced_line_uploader, attached by bind.
// Depends on eplu_pkg and echo_paced_line_uploader_assert.svh.
`default_nettype none

`include "echo_paced_line_uploader_assert.svh"

module eplu_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              cfg_we_i,
  input wire logic [eplu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input wire logic [eplu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic [eplu_pkg::BYTE_W-1:0]       s_axis_tdata_i,
  input wire logic [eplu_pkg::MODE_W-1:0]       s_axis_tuser_i,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [eplu_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input wire logic                              m_axis_tuser_o
);
  import eplu_pkg::*;

  logic [FAULT_W-1:0] fault;
  logic               unused;

  assign fault  = m_axis_tdata_o[11:10];
  assign unused = cfg_we_i ^ (^cfg_idx_i) ^ (^cfg_data_i) ^ (^s_axis_tdata_i) ^
                  (^s_axis_tuser_i) ^ s_axis_tvalid_i;

  `EPLU_ASSERT_IMPL(a_no_tx_on_refuse, m_axis_tvalid_o && m_axis_tdata_o[9],
                    !m_axis_tuser_o, "refused word also sends a byte")
  `EPLU_ASSERT_IMPL(a_fault_not_ready, m_axis_tvalid_o && (fault != FAULT_NONE),
                    !m_axis_tdata_o[8], "ready while faulted")
  `EPLU_ASSERT_IMPL(a_fault_code, m_axis_tvalid_o,
                    (fault == FAULT_NONE) || (fault == FAULT_ECHO) || (fault == FAULT_ERROR),
                    "bad fault code")
  `EPLU_ASSERT_IMPL(a_empty_takes, !m_axis_tvalid_o, s_axis_tready_o,
                    "input stalled with empty output")
  `EPLU_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
                    "stalled output word changed")

endmodule

bind echo_paced_line_uploader eplu_checker u_eplu_checker (.*);

`default_nettype wire
